// File: design/text_buffer_substring_find_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the substring find unit
// Each macro expects clk and rst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef TEXT_BUFFER_SUBSTRING_FIND_UNIT_ASSERT_SVH
`define TEXT_BUFFER_SUBSTRING_FIND_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TBSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TBSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tbsf_pkg.sv
// ----------------------------------------------------------------------------
// tbsf_pkg
// Shared constants, codes and types of the substring find unit.
// ----------------------------------------------------------------------------
package tbsf_pkg;

  // Store geometry
  localparam int TEXT_ROWS   = 256;
  localparam int LINE_COLS   = 80;
  localparam int PATTERN_MAX = 32;
  localparam int TEXT_DEPTH  = TEXT_ROWS * LINE_COLS;
  localparam int ADDR_W      = $clog2(TEXT_DEPTH);

  // Field widths
  localparam int OP_W   = 2;
  localparam int ROW_W  = 8;
  localparam int COL_W  = 7;
  localparam int PIDX_W = 5;
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 6;
  localparam int CONT_W = 9;
  localparam int VIS_W  = 8;

  localparam logic [VIS_W-1:0] VISIBLE_RESET = 8'd27;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TEXT_WR = 2'd0;
  localparam logic [OP_W-1:0] OP_PAT_WR  = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } scan_state_t;

  // Search request from the input side
  typedef struct packed {
    logic              start;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
    logic [PLEN_W-1:0] plen;
    logic [CONT_W-1:0] content;
  } scan_req_t;

  // Pattern store write
  typedef struct packed {
    logic              en;
    logic [PIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } pat_wr_t;

  // Search status and result
  typedef struct packed {
    logic              busy;
    logic              valid;
    logic              found;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CONT_W-1:0] content;
  } scan_res_t;

endpackage

// File: design/tbsf_ram.sv
// ----------------------------------------------------------------------------
// tbsf_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module tbsf_ram #(
  parameter int DEPTH  = 20480,
  parameter int DATA_W = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write on we, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/tbsf_scan.sv
// ----------------------------------------------------------------------------
// tbsf_scan
// Search sequencer: holds the pattern store, compares the returned byte and
// walks candidates: one text read per cycle, none on a mismatch or row step.
// ----------------------------------------------------------------------------
`include "text_buffer_substring_find_unit_assert.svh"

module tbsf_scan import tbsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_req_t         req,
  input  pat_wr_t           pat_wr,
  input  logic              res_take,
  output scan_res_t         res,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [BYTE_W-1:0] rd_data
);

  scan_state_t state_r, state_nxt;

  logic [BYTE_W-1:0] pat_r [PATTERN_MAX];

  // Issue pointer: candidate row and column, byte index within the pattern
  logic [CONT_W-1:0] ir_r, ir_nxt;
  logic [COL_W-1:0]  ic_r, ic_nxt;
  logic [PIDX_W-1:0] ii_r, ii_nxt;
  logic [PLEN_W-1:0] plen_r, plen_nxt;
  logic [CONT_W-1:0] content_r, content_nxt;

  // Tag of the read in flight
  logic              tag_v_r, tag_v_nxt;
  logic [ROW_W-1:0]  tag_row_r, tag_row_nxt;
  logic [COL_W-1:0]  tag_col_r, tag_col_nxt;
  logic [PIDX_W-1:0] tag_idx_r, tag_idx_nxt;
  logic              tag_last_r, tag_last_nxt;

  // Result
  logic              found_r, found_nxt;
  logic [ROW_W-1:0]  mrow_r, mrow_nxt;
  logic [COL_W-1:0]  mcol_r, mcol_nxt;

  logic              plen_bad;
  logic [CONT_W-1:0] start_content;
  logic [CONT_W-1:0] first_row;
  logic [COL_W-1:0]  first_col;
  logic [7:0]        cand_end;
  logic              row_ok;
  logic              fit;
  logic              mism;
  logic              hit;
  logic              issue;
  logic              idx_last;

  // Write the pattern store
  always_ff @(posedge clk) begin
    if (pat_wr.en && (32'(pat_wr.idx) < PATTERN_MAX)) begin
      pat_r[pat_wr.idx] <= pat_wr.data;
    end
  end

  // Decode a new search
  always_comb begin
    plen_bad = (req.plen == '0) || (32'(req.plen) > PATTERN_MAX) ||
               (32'(req.plen) > LINE_COLS);
    start_content = (32'(req.content) > TEXT_ROWS) ? CONT_W'(TEXT_ROWS) : req.content;
    if ((32'(req.ccol) + 1) < LINE_COLS) begin
      first_row = CONT_W'(req.crow);
      first_col = req.ccol + 1'b1;
    end else begin
      first_row = CONT_W'(req.crow) + 1'b1;
      first_col = '0;
    end
  end

  // Candidate checks and compare of the returned byte
  always_comb begin
    cand_end = 8'(ic_r) + 8'(plen_r);
    row_ok   = ir_r < content_r;
    fit      = cand_end <= 8'(LINE_COLS);
    mism     = tag_v_r && (rd_data != pat_r[tag_idx_r]);
    hit      = tag_v_r && !mism && tag_last_r;
    issue    = (state_r == S_SCAN) && row_ok && fit && !hit && !mism;
    idx_last = (PLEN_W'(ii_r) + 1'b1) == plen_r;
    rd_addr  = ADDR_W'(ir_r[ROW_W-1:0]) * ADDR_W'(LINE_COLS) + ADDR_W'(ic_r) +
               ADDR_W'(ii_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt = plen_bad ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_DONE;
        end else if (!mism && !row_ok && !tag_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    res.busy    = (state_r != S_IDLE);
    res.valid   = (state_r == S_DONE);
    res.found   = found_r;
    res.row     = mrow_r;
    res.col     = mcol_r;
    res.content = content_r;
    rd_en       = issue;
  end

  // Pointer, tag and result updates
  always_comb begin
    ir_nxt       = ir_r;
    ic_nxt       = ic_r;
    ii_nxt       = ii_r;
    plen_nxt     = plen_r;
    content_nxt  = content_r;
    tag_v_nxt    = 1'b0;
    tag_row_nxt  = tag_row_r;
    tag_col_nxt  = tag_col_r;
    tag_idx_nxt  = tag_idx_r;
    tag_last_nxt = tag_last_r;
    found_nxt    = found_r;
    mrow_nxt     = mrow_r;
    mcol_nxt     = mcol_r;
    if (state_r == S_IDLE) begin
      if (req.start) begin
        plen_nxt    = req.plen;
        content_nxt = start_content;
        ir_nxt      = first_row;
        ic_nxt      = first_col;
        ii_nxt      = '0;
        found_nxt   = 1'b0;
      end
    end else if (state_r == S_SCAN) begin
      if (hit) begin
        // all bytes matched
        found_nxt = 1'b1;
        mrow_nxt  = tag_row_r;
        mcol_nxt  = tag_col_r;
      end else if (mism) begin
        // drop the read in flight, restart one column past the failed candidate
        ir_nxt = CONT_W'(tag_row_r);
        ic_nxt = tag_col_r + 1'b1;
        ii_nxt = '0;
      end else if (issue) begin
        tag_v_nxt    = 1'b1;
        tag_row_nxt  = ir_r[ROW_W-1:0];
        tag_col_nxt  = ic_r;
        tag_idx_nxt  = ii_r;
        tag_last_nxt = idx_last;
        if (idx_last) begin
          ic_nxt = ic_r + 1'b1;
          ii_nxt = '0;
        end else begin
          ii_nxt = ii_r + 1'b1;
        end
      end else if (row_ok) begin
        // candidate runs past the line end: advance to the next row
        ir_nxt = ir_r + 1'b1;
        ic_nxt = '0;
        ii_nxt = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tag_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_v_r <= tag_v_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ir_r       <= ir_nxt;
    ic_r       <= ic_nxt;
    ii_r       <= ii_nxt;
    plen_r     <= plen_nxt;
    content_r  <= content_nxt;
    tag_row_r  <= tag_row_nxt;
    tag_col_r  <= tag_col_nxt;
    tag_idx_r  <= tag_idx_nxt;
    tag_last_r <= tag_last_nxt;
    found_r    <= found_nxt;
    mrow_r     <= mrow_nxt;
    mcol_r     <= mcol_nxt;
  end

  `TBSF_ASSERT_IMP(a_tag_only_in_scan, tag_v_r, state_r == S_SCAN, "read in flight outside scan")
  `TBSF_ASSERT_NXT(a_issue_tagged, rd_en, tag_v_r, "issued read has no tag")
  `TBSF_ASSERT_NXT(a_hit_done, hit, (state_r == S_DONE) && found_r, "match not reported")
  `TBSF_ASSERT_IMP(a_match_in_content, res.valid && res.found, 9'(res.row) < res.content, "match row past content end")

endmodule

// File: design/text_buffer_substring_find_unit.sv
// ----------------------------------------------------------------------------
// text_buffer_substring_find_unit
// A text or pattern write item gives no result. A search reads text bytes,
// spends an idle step on each mismatch and advances rows until it is done; a
// bad length goes straight to done. The input stalls until the result enters
// the output register.
// Reset: synchronous, clears control state and sets visible rows to 27; the
// text and pattern stores are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
module text_buffer_substring_find_unit import tbsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_col,
  input  logic [PIDX_W-1:0] in_pattern_index,
  input  logic [BYTE_W-1:0] in_byte_value,
  input  logic [PLEN_W-1:0] in_pattern_length,
  input  logic [CONT_W-1:0] in_content_rows,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [ROW_W-1:0]  out_match_row,
  output logic [COL_W-1:0]  out_match_col,
  output logic [ROW_W-1:0]  out_scroll_top,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [VIS_W-1:0]  cfg_visible_rows
);

  logic [VIS_W-1:0] vis_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_top_r, out_top_nxt;

  scan_req_t         req;
  pat_wr_t           pat_wr;
  scan_res_t         res;
  logic              res_take;
  logic              in_acc;
  logic              text_we;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_rdata;

  logic [VIS_W-1:0]  vis;
  logic [CONT_W-1:0] vis_ext;
  logic [CONT_W-1:0] half;
  logic [CONT_W-1:0] top;
  logic [CONT_W-1:0] top_lim;

  // Accept items only while no search runs
  assign in_stall  = res.busy;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Decode the accepted item
  always_comb begin
    req.start   = in_acc && (in_operation == OP_SEARCH);
    req.crow    = in_row;
    req.ccol    = in_col;
    req.plen    = in_pattern_length;
    req.content = in_content_rows;
    pat_wr.en   = in_acc && (in_operation == OP_PAT_WR);
    pat_wr.idx  = in_pattern_index;
    pat_wr.data = in_byte_value;
    text_we     = in_acc && (in_operation == OP_TEXT_WR) &&
                  (32'(in_row) < TEXT_ROWS) && (32'(in_col) < LINE_COLS);
    ram_addr    = text_we ? (ADDR_W'(in_row) * ADDR_W'(LINE_COLS) + ADDR_W'(in_col))
                          : rd_addr;
  end

  tbsf_ram #(
    .DEPTH  (TEXT_DEPTH),
    .DATA_W (BYTE_W)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .addr  (ram_addr),
    .wdata (in_byte_value),
    .rdata (ram_rdata)
  );

  tbsf_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req),
    .pat_wr   (pat_wr),
    .res_take (res_take),
    .res      (res),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (ram_rdata)
  );

  // Hold the visible row count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r <= VISIBLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vis_r <= cfg_visible_rows;
    end
  end

  // Center the match, clamp to the content end
  always_comb begin
    vis     = (vis_r == '0) ? VIS_W'(1) : vis_r;
    vis_ext = CONT_W'(vis);
    half    = CONT_W'(vis[VIS_W-1:1]);
    top_lim = res.content - vis_ext;
    top     = '0;
    if (CONT_W'(res.row) > half) begin
      top = CONT_W'(res.row) - half;
      if ((res.content > vis_ext) && (top > top_lim)) begin
        top = top_lim;
      end
    end
  end

  // Load the output register when it is free or being drained
  always_comb begin
    res_take      = res.valid && (!out_valid_r || !out_stall);
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_top_nxt   = out_top_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res.found;
      out_row_nxt   = res.found ? res.row : '0;
      out_col_nxt   = res.found ? res.col : '0;
      out_top_nxt   = res.found ? top[ROW_W-1:0] : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_top_r   <= out_top_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_match_row  = out_row_r;
  assign out_match_col  = out_col_r;
  assign out_scroll_top = out_top_r;

endmodule

// File: test/tb_text_buffer_substring_find_unit.sv
// ----------------------------------------------------------------------------
// tb_text_buffer_substring_find_unit
// Self-checking bench for the substring find unit. A short stimulus table
// covers field extremes, ignored writes, the unused operation and the
// boundary cursor cases; random write and search traffic follows over
// several visible-row settings. Every search result is checked against the
// table's typed result or a local copy of the text and pattern stores.
// Searches only ever scan store entries that the bench has written.
// ----------------------------------------------------------------------------
module tb_text_buffer_substring_find_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tbsf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Written layout: a few full rows at the top, plus row tails further down
  localparam int DENSE_ROWS = 4;
  localparam int TAIL_COL = 60;
  localparam int TAIL_ROWS [4] = '{127, 200, 254, 255};

  localparam int PHASE_ITEMS = 125;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 100;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PIDX_W-1:0] pidx;
    logic [BYTE_W-1:0] value;
    logic [PLEN_W-1:0] plen;
    logic [CONT_W-1:0] content;
  } cmd_t;

  typedef struct packed {
    logic              found;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  top;
  } hit_t;

  typedef struct packed {
    cmd_t cmd;
    logic typed;
    hit_t want;
  } step_t;

  localparam hit_t NO_HIT = '0;
  localparam hit_t ANY = '0;
  localparam int N_STEPS = 21;

  // Directed items; typed rows carry their result, the rest use the predictor
  localparam step_t STEPS [N_STEPS] = '{
    '{'{OP_SEARCH,  8'd0,   7'd0,   5'd0,  8'h00, 6'd0,  9'd256}, 1'b1, NO_HIT},
    '{'{OP_SEARCH,  8'd0,   7'd0,   5'd0,  8'h00, 6'd33, 9'd511}, 1'b1, NO_HIT},
    '{'{OP_SEARCH,  8'd255, 7'd127, 5'd31, 8'hFF, 6'd63, 9'd511}, 1'b1, NO_HIT},
    '{'{OP_UNUSED,  8'd255, 7'd127, 5'd31, 8'hFF, 6'd63, 9'd511}, 1'b0, ANY},
    '{'{OP_TEXT_WR, 8'd0,   7'd127, 5'd0,  8'hFF, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_TEXT_WR, 8'd255, 7'd79,  5'd0,  8'hFF, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_TEXT_WR, 8'd255, 7'd78,  5'd0,  8'h00, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_TEXT_WR, 8'd255, 7'd77,  5'd0,  8'h41, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_PAT_WR,  8'd0,   7'd0,   5'd0,  8'h00, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_PAT_WR,  8'd0,   7'd0,   5'd1,  8'hFF, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_PAT_WR,  8'd0,   7'd0,   5'd31, 8'h80, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd76,  5'd0,  8'h00, 6'd2,  9'd256}, 1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd76,  5'd0,  8'h00, 6'd2,  9'd511}, 1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd79,  5'd0,  8'h00, 6'd1,  9'd511}, 1'b1, NO_HIT},
    '{'{OP_SEARCH,  8'd255, 7'd127, 5'd0,  8'h00, 6'd2,  9'd256}, 1'b1, NO_HIT},
    '{'{OP_SEARCH,  8'd255, 7'd78,  5'd0,  8'h00, 6'd1,  9'd256}, 1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd77,  5'd0,  8'h00, 6'd1,  9'd256}, 1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd76,  5'd0,  8'h00, 6'd1,  9'd0},   1'b1, NO_HIT},
    '{'{OP_SEARCH,  8'd0,   7'd0,   5'd0,  8'h00, 6'd32, 9'd0},   1'b1, NO_HIT},
    '{'{OP_PAT_WR,  8'd0,   7'd0,   5'd0,  8'hFF, 6'd0,  9'd0},   1'b0, ANY},
    '{'{OP_SEARCH,  8'd255, 7'd76,  5'd0,  8'h00, 6'd1,  9'd256}, 1'b0, ANY}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [PIDX_W-1:0] in_pattern_index;
  logic [BYTE_W-1:0] in_byte_value;
  logic [PLEN_W-1:0] in_pattern_length;
  logic [CONT_W-1:0] in_content_rows;
  logic              out_valid;
  logic              out_stall;
  logic              out_found;
  logic [ROW_W-1:0]  out_match_row;
  logic [COL_W-1:0]  out_match_col;
  logic [ROW_W-1:0]  out_scroll_top;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [VIS_W-1:0]  cfg_visible_rows;

  // Local copy of the block state
  logic [BYTE_W-1:0] text_copy [TEXT_DEPTH];
  bit                text_written [TEXT_DEPTH];
  logic [BYTE_W-1:0] pattern_copy [PATTERN_MAX];
  bit                pattern_written [PATTERN_MAX];
  logic [VIS_W-1:0]  visible_copy;

  hit_t pending_hits [$];
  int   err_count;
  int   live_items;
  int   hold_cycles;
  int   cycle_count;
  bit   quiet;

  text_buffer_substring_find_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_row            (in_row),
    .in_col            (in_col),
    .in_pattern_index  (in_pattern_index),
    .in_byte_value     (in_byte_value),
    .in_pattern_length (in_pattern_length),
    .in_content_rows   (in_content_rows),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_row     (out_match_row),
    .out_match_col     (out_match_col),
    .out_scroll_top    (out_scroll_top),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_visible_rows  (cfg_visible_rows)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
    err_count++;
  endtask

  // Work out a search result; returns 0 when the scan could touch an
  // entry that was never written
  function automatic bit search_outcome(input cmd_t cmd, output hit_t res);
    int cont, vis, srow, scol, r, c, i, half, top, plen;
    bit hit;
    res = '0;
    plen = int'(cmd.plen);
    cont = (int'(cmd.content) > TEXT_ROWS) ? TEXT_ROWS : int'(cmd.content);
    vis = (visible_copy == 0) ? 1 : int'(visible_copy);
    if (plen == 0 || plen > PATTERN_MAX || plen > LINE_COLS) return 1'b1;
    if (int'(cmd.col) + 1 < LINE_COLS) begin
      srow = int'(cmd.row);
      scol = int'(cmd.col) + 1;
    end else begin
      srow = int'(cmd.row) + 1;
      scol = 0;
    end
    if (srow >= cont) return 1'b1;
    for (i = 0; i < plen; i++) begin
      if (!pattern_written[i]) return 1'b0;
    end
    for (r = srow; r < cont; r++) begin
      c = (r == srow) ? scol : 0;
      for (i = c; i < LINE_COLS; i++) begin
        if (!text_written[r * LINE_COLS + i]) return 1'b0;
      end
      for (; c + plen <= LINE_COLS; c++) begin
        hit = 1'b1;
        for (i = 0; i < plen && hit; i++) begin
          if (text_copy[r * LINE_COLS + c + i] != pattern_copy[i]) hit = 1'b0;
        end
        if (hit) begin
          half = vis / 2;
          if (r > half) begin
            top = r - half;
            if (cont > vis && top > cont - vis) top = cont - vis;
          end else begin
            top = 0;
          end
          res.found = 1'b1;
          res.row = ROW_W'(r);
          res.col = COL_W'(c);
          res.top = ROW_W'(top);
          return 1'b1;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic cmd_t random_cmd(input logic [OP_W-1:0] op);
    cmd_t cmd;
    cmd.op = op;
    cmd.row = ROW_W'($urandom);
    cmd.col = COL_W'($urandom);
    cmd.pidx = PIDX_W'($urandom);
    cmd.value = BYTE_W'($urandom);
    cmd.plen = PLEN_W'($urandom);
    cmd.content = CONT_W'($urandom);
    return cmd;
  endfunction

  // Mostly a three-letter alphabet so that short patterns often match
  function automatic logic [BYTE_W-1:0] pick_char();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom);
    if ($urandom_range(0, 15) != 0) b = BYTE_W'(8'h61 + $urandom_range(0, 2));
    return b;
  endfunction

  function automatic logic [PLEN_W-1:0] pick_length();
    case ($urandom_range(0, 7))
      0: return PLEN_W'($urandom_range(0, 63));
      1: return PLEN_W'($urandom_range(5, PATTERN_MAX));
      default: return PLEN_W'($urandom_range(1, 4));
    endcase
  endfunction

  // Draw a search whose scan stays within written entries
  function automatic cmd_t build_search(input logic [PLEN_W-1:0] plen);
    cmd_t cmd;
    hit_t unused_hit;
    int tries, pick;
    cmd = random_cmd(OP_SEARCH);
    cmd.plen = plen;
    for (tries = 0; tries < 16; tries++) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        cmd.row = ROW_W'($urandom_range(0, DENSE_ROWS));
        cmd.col = COL_W'($urandom_range(0, 127));
        case ($urandom_range(0, 3))
          0: cmd.content = CONT_W'($urandom_range(0, 511));
          1: cmd.content = CONT_W'($urandom_range(TEXT_ROWS, 511));
          default: cmd.content = CONT_W'($urandom_range(0, DENSE_ROWS + 1));
        endcase
      end else if (pick < 9) begin
        cmd.row = ROW_W'(TAIL_ROWS[$urandom_range(0, 3)]);
        cmd.col = COL_W'($urandom_range(TAIL_COL - 1, 127));
        if ($urandom_range(0, 1)) cmd.content = CONT_W'(cmd.row) + 1'b1;
        else cmd.content = CONT_W'($urandom_range(0, 511));
      end else begin
        cmd.row = ROW_W'($urandom);
        cmd.col = COL_W'($urandom);
        cmd.content = CONT_W'($urandom_range(0, cmd.row));
      end
      if (search_outcome(cmd, unused_hit)) return cmd;
    end
    // Cursor at the content end: nothing is scanned
    cmd.content = CONT_W'(cmd.row);
    return cmd;
  endfunction

  // Offer one item, hold it until accepted, then update the local state
  task automatic send_item(input cmd_t cmd, input logic typed = 1'b0,
                           input hit_t want = '0);
    int idx;
    hit_t hit;
    in_valid <= 1'b1;
    in_operation <= cmd.op;
    in_row <= cmd.row;
    in_col <= cmd.col;
    in_pattern_index <= cmd.pidx;
    in_byte_value <= cmd.value;
    in_pattern_length <= cmd.plen;
    in_content_rows <= cmd.content;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    case (cmd.op)
      OP_TEXT_WR: begin
        if (cmd.row < TEXT_ROWS && cmd.col < LINE_COLS) begin
          idx = int'(cmd.row) * LINE_COLS + int'(cmd.col);
          text_copy[idx] = cmd.value;
          text_written[idx] = 1'b1;
        end
      end
      OP_PAT_WR: begin
        if (cmd.pidx < PATTERN_MAX) begin
          pattern_copy[cmd.pidx] = cmd.value;
          pattern_written[cmd.pidx] = 1'b1;
        end
      end
      OP_SEARCH: begin
        void'(search_outcome(cmd, hit));
        pending_hits.push_back(typed ? want : hit);
      end
      default: ;
    endcase
    if (!(cmd.op == OP_UNUSED || (cmd.op == OP_TEXT_WR && cmd.col >= LINE_COLS))) begin
      live_items++;
    end
    // Random sender gap
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic text_write(input int r, input int c, input logic [BYTE_W-1:0] v);
    cmd_t cmd;
    cmd = random_cmd(OP_TEXT_WR);
    cmd.row = ROW_W'(r);
    cmd.col = COL_W'(c);
    cmd.value = v;
    send_item(cmd);
  endtask

  task automatic pattern_write(input int i, input logic [BYTE_W-1:0] v);
    cmd_t cmd;
    cmd = random_cmd(OP_PAT_WR);
    cmd.pidx = PIDX_W'(i);
    cmd.value = v;
    send_item(cmd);
  endtask

  // Drop valid and wait until every expected result is back
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_visible(input logic [VIS_W-1:0] rows);
    settle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_visible_rows <= rows;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    visible_copy = rows;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_episode();
    int kind, n, i, src_row, src_col, max_len, len;
    cmd_t cmd;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // Copy a piece of text into the pattern, then look for it
      if ($urandom_range(0, 3) == 0) begin
        src_row = TAIL_ROWS[$urandom_range(0, 3)];
        src_col = $urandom_range(TAIL_COL, LINE_COLS - 1);
      end else begin
        src_row = $urandom_range(0, DENSE_ROWS - 1);
        src_col = $urandom_range(0, LINE_COLS - 1);
      end
      max_len = LINE_COLS - src_col;
      if (max_len > PATTERN_MAX) max_len = PATTERN_MAX;
      len = $urandom_range(1, (max_len < 4) ? max_len : 4);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, max_len);
      for (i = 0; i < len; i++) begin
        pattern_write(i, text_copy[src_row * LINE_COLS + src_col + i]);
      end
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) send_item(build_search(PLEN_W'(len)));
    end else if (kind < 55) begin
      send_item(build_search(pick_length()));
    end else if (kind < 80) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          text_write(TAIL_ROWS[$urandom_range(0, 3)],
                     $urandom_range(TAIL_COL, LINE_COLS - 1), pick_char());
        end else begin
          text_write($urandom_range(0, DENSE_ROWS - 1),
                     $urandom_range(0, LINE_COLS - 1), pick_char());
        end
      end
    end else if (kind < 88) begin
      pattern_write($urandom_range(0, PATTERN_MAX - 1), pick_char());
    end else begin
      // Noise: unused operation or out-of-range text write
      cmd = random_cmd(OP_UNUSED);
      if ($urandom_range(0, 1)) begin
        cmd.op = OP_TEXT_WR;
        cmd.col = COL_W'($urandom_range(LINE_COLS, 127));
      end
      send_item(cmd);
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    hit_t exp_hit;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_hits.size() == 0) begin
        report_error($sformatf("result with none expected: found %0b row %0d col %0d",
                               out_found, out_match_row, out_match_col));
      end else begin
        exp_hit = pending_hits.pop_front();
        if (out_found !== exp_hit.found)
          report_error($sformatf("found %b, want %b", out_found, exp_hit.found));
        if (out_match_row !== exp_hit.row)
          report_error($sformatf("match_row %0d, want %0d", out_match_row, exp_hit.row));
        if (out_match_col !== exp_hit.col)
          report_error($sformatf("match_col %0d, want %0d", out_match_col, exp_hit.col));
        if (out_scroll_top !== exp_hit.top)
          report_error($sformatf("scroll_top %0d, want %0d", out_scroll_top, exp_hit.top));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold when requested
  initial begin : rx_side
    int left;
    bit stalling;
    left = 0;
    stalling = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        stalling = 1'b1;
      end else if (left > 0) begin
        left--;
      end else begin
        stalling = stalling ? 1'b0 : (!quiet && $urandom_range(0, 5) == 0);
        left = stalling ? $urandom_range(0, 12) : $urandom_range(0, 20);
      end
      out_stall <= stalling;
    end
  end

  // Cycle counter; end the run if it hangs
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_buffer_substring_find_unit test failed");
    $finish;
  end

  initial begin : main_seq
    int i, r, c, ph, start;
    bit paused;
    logic [VIS_W-1:0] vis;
    err_count = 0;
    live_items = 0;
    hold_cycles = 0;
    quiet = 1'b0;
    paused = 1'b0;
    visible_copy = VISIBLE_RESET;
    for (i = 0; i < TEXT_DEPTH; i++) text_written[i] = 1'b0;
    for (i = 0; i < PATTERN_MAX; i++) pattern_written[i] = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= '0;
    in_row <= '0;
    in_col <= '0;
    in_pattern_index <= '0;
    in_byte_value <= '0;
    in_pattern_length <= '0;
    in_content_rows <= '0;
    cfg_valid <= 1'b0;
    cfg_visible_rows <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the stimulus table at the reset visible-row setting
    for (i = 0; i < N_STEPS; i++) begin
      send_item(STEPS[i].cmd, STEPS[i].typed, STEPS[i].want);
    end

    // Fill the dense rows, the whole pattern and the row tails
    for (r = 0; r < DENSE_ROWS; r++) begin
      for (c = 0; c < LINE_COLS; c++) text_write(r, c, pick_char());
    end
    for (i = 0; i < PATTERN_MAX; i++) pattern_write(i, pick_char());
    for (i = 0; i < 4; i++) begin
      for (c = TAIL_COL; c < LINE_COLS; c++) text_write(TAIL_ROWS[i], c, pick_char());
    end

    // Random traffic over several visible-row settings
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: vis = 8'd1;
        1: vis = 8'd255;
        2: vis = 8'd0;
        3: vis = VIS_W'($urandom_range(2, 254));
        default: vis = 8'd7;
      endcase
      write_visible(vis);
      quiet = (ph == 4);
      start = live_items;
      if (ph == 1) begin
        // Hold the receiver off while searches keep coming
        hold_cycles = HOLD_CYCLES;
        for (i = 0; i < 6; i++) send_item(build_search(pick_length()));
      end
      while (live_items - start < PHASE_ITEMS) begin
        run_episode();
        if (ph == 2 && !paused && live_items - start >= PHASE_ITEMS / 2) begin
          settle(0);
          paused = 1'b1;
        end
      end
    end

    settle(0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("text_buffer_substring_find_unit test passed");
    end else begin
      $display("text_buffer_substring_find_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/tbsf_pkg.sv
design/tbsf_ram.sv
design/tbsf_scan.sv
design/text_buffer_substring_find_unit.sv
test/tb_text_buffer_substring_find_unit.sv
